/* sv/pwl_pkg.sv */
// ----------------------------------------------------------------------------
// pwl_pkg
// Shared types and constants of the piecewise linear interpolator.
// ----------------------------------------------------------------------------
package pwl_pkg;

    localparam int MAX_POINTS = 64;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);

    // input modes
    localparam logic [1:0] MODE_APPEND = 2'd0;
    localparam logic [1:0] MODE_QUERY  = 2'd1;
    localparam logic [1:0] MODE_CLEAR  = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    // decoded operations
    localparam logic [1:0] OP_APPEND = 2'd0;
    localparam logic [1:0] OP_QUERY  = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;
    localparam logic [1:0] OP_NOP    = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_FEW        = 2'd1;
    localparam logic [1:0] ST_FULL       = 2'd2;
    localparam logic [1:0] ST_ZERO_WIDTH = 2'd3;

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [31:0] key_x;
        logic signed [31:0] value_y;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] result_y;
        logic [1:0]         status;
        logic [6:0]         entries_held;
    } t_out_item;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [31:0] key_x;
        logic signed [31:0] value_y;
    } t_cmd;

endpackage

/* sv/piecewise_linear_interpolator.sv */
// ----------------------------------------------------------------------------
// piecewise_linear_interpolator
// Breakpoint table with linear interpolation queries in signed Q16.16.
// ----------------------------------------------------------------------------
// Input queue: present an item and raise push; it transfers when full is low.
// Result queue: while empty is low the oldest result is on o_result; raise
// pop to transfer it. Every item gives exactly one result, in order.
// Config: i_cfg_we writes i_cfg_data (extrapolate enable) on any edge.
// A two-entry command queue sits in front of the engine, so items are taken
// while the engine works or a result waits.
// Order of work: append, clear and unused mode go straight to the result stage.
// A query reads the last two breakpoints, scans the table for its interval,
// reads both ends, then runs a 32x32 multiply and a 64-step serial divider
// before its result is registered. Items are worked one at a time.
// Reset: the table count, queues and extrapolate enable clear; table
// contents are left as they were. If pop stays low the result register
// holds, the engine waits with its next result and the input queue fills.
// ----------------------------------------------------------------------------
module piecewise_linear_interpolator (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_data,
    input  logic               push,
    output logic               full,
    input  pwl_pkg::t_in_item  i_item,
    output logic               empty,
    input  logic               pop,
    output pwl_pkg::t_out_item o_result
);
    import pwl_pkg::*;

    logic r_extrap;
    logic cmd_valid;
    logic cmd_take;
    t_cmd cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_extrap <= 1'b0;
        end else if (i_cfg_we) begin
            r_extrap <= i_cfg_data;
        end
    end

    pwl_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_item      (i_item),
        .full        (full),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_take  (cmd_take)
    );

    pwl_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_extrap    (r_extrap),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_take  (cmd_take),
        .empty       (empty),
        .o_item      (o_result),
        .pop         (pop)
    );

endmodule

/* sv/pwl_front.sv */
// ----------------------------------------------------------------------------
// pwl_front
// Accepts input items, decodes the mode and queues commands for the engine.
// ----------------------------------------------------------------------------
module pwl_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  pwl_pkg::t_in_item i_item,
    output logic              full,
    output logic              o_cmd_valid,
    output pwl_pkg::t_cmd     o_cmd,
    input  logic              i_cmd_take
);
    import pwl_pkg::*;

    t_cmd       r_buf [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       wr_en;
    logic       rd_en;
    t_cmd       cmd_in;

    assign full        = (r_cnt == 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_buf[r_rp];
    assign wr_en       = i_push && !full;
    assign rd_en       = o_cmd_valid && i_cmd_take;

    always_comb begin
        cmd_in.key_x   = i_item.key_x;
        cmd_in.value_y = i_item.value_y;
        unique case (i_item.mode)
            MODE_APPEND: cmd_in.op = OP_APPEND;
            MODE_QUERY:  cmd_in.op = OP_QUERY;
            MODE_CLEAR:  cmd_in.op = OP_CLEAR;
            default:     cmd_in.op = OP_NOP;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_buf[r_wp] <= cmd_in;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (wr_en) begin
                r_wp <= ~r_wp;
            end
            if (rd_en) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, wr_en} - {1'b0, rd_en};
        end
    end

endmodule

/* sv/pwl_engine.sv */
// ----------------------------------------------------------------------------
// pwl_engine
// Breakpoint table, interval search, multiply, serial divide and result register.
// ----------------------------------------------------------------------------
module pwl_engine (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_extrap,
    input  logic               i_cmd_valid,
    input  pwl_pkg::t_cmd      i_cmd,
    output logic               o_cmd_take,
    output logic               empty,
    output pwl_pkg::t_out_item o_item,
    input  logic               pop
);
    import pwl_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_PEN1 = 4'd1;
    localparam logic [3:0] S_PEN2 = 4'd2;
    localparam logic [3:0] S_SCAN = 4'd3;
    localparam logic [3:0] S_GETL = 4'd4;
    localparam logic [3:0] S_GETR = 4'd5;
    localparam logic [3:0] S_CALC = 4'd6;
    localparam logic [3:0] S_MUL  = 4'd7;
    localparam logic [3:0] S_DIV  = 4'd8;
    localparam logic [3:0] S_FIN  = 4'd9;
    localparam logic [3:0] S_DONE = 4'd10;

    logic signed [31:0] mem_x [MAX_POINTS];
    logic signed [31:0] mem_y [MAX_POINTS];

    logic [3:0]         r_state;
    logic [CNT_W-1:0]   r_count;
    logic [IDX_W-1:0]   r_i;
    logic [IDX_W-1:0]   r_j;
    logic signed [31:0] r_x;
    logic signed [31:0] r_xlast;
    logic signed [31:0] r_rdx;
    logic signed [31:0] r_rdy;
    logic signed [31:0] r_xl;
    logic signed [31:0] r_yl;
    logic signed [31:0] r_xr;
    logic signed [31:0] r_yr;
    logic [31:0]        r_da;
    logic [31:0]        r_dya;
    logic [31:0]        r_dv;
    logic               r_neg;
    logic [63:0]        r_quo;
    logic [31:0]        r_rem;
    logic [5:0]         r_k;
    t_out_item          r_pend;
    t_out_item          r_out;
    logic               r_ovalid;

    logic [IDX_W-1:0]   rd_addr;
    logic               wr_en;
    logic [CNT_W-1:0]   n_m1;
    logic [CNT_W-1:0]   n_m2;
    logic signed [31:0] h_yl;
    logic signed [31:0] h_yr;
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic signed [32:0] dd;
    logic [32:0]        rem_sh;
    logic               q_bit;
    logic [34:0]        q_clip;
    logic signed [36:0] sum;
    logic signed [31:0] sat;
    logic               out_free;

    function automatic logic [31:0] mag33(input logic signed [32:0] v);
        logic signed [32:0] a;
        a = v[32] ? -v : v;
        return a[31:0];
    endfunction

    assign n_m1       = r_count - CNT_W'(1);
    assign n_m2       = r_count - CNT_W'(2);
    assign o_cmd_take = (r_state == S_IDLE) && i_cmd_valid;
    assign wr_en      = o_cmd_take && (i_cmd.op == OP_APPEND)
                        && (r_count < CNT_W'(MAX_POINTS));
    assign out_free   = !r_ovalid || pop;
    assign empty      = !r_ovalid;
    assign o_item     = r_out;

    always_comb begin
        unique case (r_state)
            S_IDLE:  rd_addr = n_m1[IDX_W-1:0];
            S_PEN1:  rd_addr = n_m2[IDX_W-1:0];
            S_PEN2:  rd_addr = (r_x >= r_rdx) ? n_m2[IDX_W-1:0] : IDX_W'(1);
            S_SCAN:  rd_addr = (({1'b0, r_j} == n_m1) || (r_x <= r_rdx))
                               ? r_j - IDX_W'(1) : r_j + IDX_W'(1);
            S_GETL:  rd_addr = r_i + IDX_W'(1);
            default: rd_addr = r_i;
        endcase
    end

    // held ends when extrapolation is off
    always_comb begin
        h_yl = r_yl;
        h_yr = r_yr;
        if (!i_extrap) begin
            if (r_x < r_xl) begin
                h_yr = h_yl;
            end
            if (r_x > r_xr) begin
                h_yl = h_yr;
            end
        end
        dx = 33'(r_xr) - 33'(r_xl);
        dy = 33'(h_yr) - 33'(h_yl);
        dd = 33'(r_x) - 33'(r_xl);
    end

    assign rem_sh = {r_rem, r_quo[63]};
    assign q_bit  = (rem_sh >= {1'b0, r_dv});
    assign q_clip = (r_quo > 64'h4_0000_0000) ? 35'h4_0000_0000 : r_quo[34:0];
    assign sum    = 37'(r_yl) + (r_neg ? -37'(q_clip) : 37'(q_clip));

    always_comb begin
        if (sum > 37'sd2147483647) begin
            sat = 32'sh7fff_ffff;
        end else if (sum < -37'sd2147483648) begin
            sat = 32'sh8000_0000;
        end else begin
            sat = sum[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_x[r_count[IDX_W-1:0]] <= i_cmd.key_x;
            mem_y[r_count[IDX_W-1:0]] <= i_cmd.value_y;
        end
        r_rdx <= mem_x[rd_addr];
        r_rdy <= mem_y[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (pop && r_ovalid) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_x                <= i_cmd.key_x;
                        r_pend.result_y    <= '0;
                        r_pend.status      <= ST_OK;
                        r_pend.entries_held <= 7'(r_count);
                        r_state            <= S_DONE;
                        case (i_cmd.op)
                            OP_APPEND: begin
                                if (wr_en) begin
                                    r_count             <= r_count + CNT_W'(1);
                                    r_pend.entries_held <= 7'(r_count + CNT_W'(1));
                                end else begin
                                    r_pend.status <= ST_FULL;
                                end
                            end
                            OP_QUERY: begin
                                if (r_count < CNT_W'(2)) begin
                                    r_pend.status <= ST_FEW;
                                end else begin
                                    r_state <= S_PEN1;
                                end
                            end
                            OP_CLEAR: begin
                                r_count             <= '0;
                                r_pend.entries_held <= '0;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_PEN1: begin
                    r_xlast <= r_rdx;
                    r_state <= S_PEN2;
                end
                S_PEN2: begin
                    if (r_x >= r_rdx) begin
                        r_i     <= n_m2[IDX_W-1:0];
                        r_state <= S_GETL;
                    end else begin
                        r_j     <= IDX_W'(1);
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (({1'b0, r_j} == n_m1) || (r_x <= r_rdx)) begin
                        r_i     <= r_j - IDX_W'(1);
                        r_state <= S_GETL;
                    end else begin
                        r_j <= r_j + IDX_W'(1);
                    end
                end
                S_GETL: begin
                    r_xl    <= r_rdx;
                    r_yl    <= r_rdy;
                    r_state <= S_GETR;
                end
                S_GETR: begin
                    r_xr    <= r_rdx;
                    r_yr    <= r_rdy;
                    r_state <= S_CALC;
                end
                S_CALC: begin
                    r_yl  <= h_yl;
                    r_da  <= mag33(dd);
                    r_dya <= mag33(dy);
                    r_dv  <= mag33(dx);
                    r_neg <= dd[32] ^ dy[32] ^ dx[32];
                    if (r_x == r_xlast) begin
                        r_state <= S_DONE;
                    end else if (dx == 33'sd0) begin
                        r_pend.status <= ST_ZERO_WIDTH;
                        r_state       <= S_DONE;
                    end else begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_quo   <= 64'(r_da) * 64'(r_dya);
                    r_rem   <= '0;
                    r_k     <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    // one quotient bit per cycle, restoring
                    r_rem <= q_bit ? 32'(rem_sh - {1'b0, r_dv}) : rem_sh[31:0];
                    r_quo <= {r_quo[62:0], q_bit};
                    r_k   <= r_k + 6'd1;
                    if (r_k == 6'd63) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    r_pend.result_y <= sat;
                    r_state         <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out    <= r_pend;
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

/* tb/sv/tb_piecewise_linear_interpolator.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_piecewise_linear_interpolator
// Self-checking bench: table builds and queries are predicted in Q16.16 and
// every result transfer is compared against the oldest predicted result.
// ----------------------------------------------------------------------------
module tb_piecewise_linear_interpolator;
    import pwl_pkg::*;

    localparam int CYCLE_LIMIT = 1500000;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_cfg_we;
    logic      i_cfg_data;
    logic      push;
    logic      full;
    t_in_item  i_item;
    logic      empty;
    logic      pop;
    t_out_item o_result;

    piecewise_linear_interpolator u_top (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_data(i_cfg_data),
        .push      (push),
        .full      (full),
        .i_item    (i_item),
        .empty     (empty),
        .pop       (pop),
        .o_result  (o_result)
    );

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // table copy kept alongside the block
    int          table_x [MAX_POINTS];
    int          table_y [MAX_POINTS];
    int          num_points;
    bit          extrap_on;

    t_in_item    pending_items[$];
    t_out_item   expected_results[$];
    int          send_idle_pct;
    int          recv_idle_pct;
    int          errors;
    int          cycles;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic longint unsigned magnitude(input longint v);
        return v < 0 ? longint'(-v) : v;
    endfunction

    function automatic t_out_item interpolate_or_update(input t_in_item it);
        t_out_item r;
        int i;
        longint xl, yl, xr, yr, dx, dy, d, term, sum;
        longint unsigned q;
        bit neg;
        r = '0;
        r.status = ST_OK;
        case (it.mode)
            MODE_APPEND: begin
                if (num_points >= MAX_POINTS) begin
                    r.status = ST_FULL;
                end else begin
                    table_x[num_points] = it.key_x;
                    table_y[num_points] = it.value_y;
                    num_points++;
                end
            end
            MODE_QUERY: begin
                if (num_points < 2) begin
                    r.status = ST_FEW;
                end else begin
                    i = 0;
                    if (it.key_x >= table_x[num_points-2]) begin
                        i = num_points - 2;
                    end else begin
                        while (i + 1 < num_points - 1 && it.key_x > table_x[i+1]) i++;
                    end
                    xl = table_x[i];
                    yl = table_y[i];
                    xr = table_x[i+1];
                    yr = table_y[i+1];
                    if (!extrap_on) begin
                        if (longint'(it.key_x) < xl) yr = yl;
                        if (longint'(it.key_x) > xr) yl = yr;
                    end
                    dx = xr - xl;
                    // exact hit on the last breakpoint gives zero before width check
                    if (it.key_x == table_x[num_points-1]) begin
                        r.status = ST_OK;
                    end else if (dx == 0) begin
                        r.status = ST_ZERO_WIDTH;
                    end else begin
                        dy = yr - yl;
                        d = longint'(it.key_x) - xl;
                        q = (magnitude(d) * magnitude(dy)) / magnitude(dx);
                        if (q > (64'd1 << 34)) q = 64'd1 << 34;
                        neg = ((d < 0) != (dy < 0)) != (dx < 0);
                        term = neg ? -longint'(q) : longint'(q);
                        sum = yl + term;
                        if (sum > 64'sh7fffffff) sum = 64'sh7fffffff;
                        if (sum < -64'sh80000000) sum = -64'sh80000000;
                        r.result_y = sum[31:0];
                    end
                end
            end
            MODE_CLEAR: num_points = 0;
            default: ;
        endcase
        r.entries_held = num_points[6:0];
        return r;
    endfunction

    // driver: next item is taken from the pending queue after each transfer
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
            i_item <= '0;
        end else begin
            int k;
            k = 0;
            if (push && !full) begin
                expected_results.push_back(interpolate_or_update(pending_items[0]));
                k = 1;
            end
            if (k == 1) void'(pending_items.pop_front());
            if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                push <= 1'b1;
                i_item <= pending_items[0];
            end else begin
                push <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (expected_results.size() == 0) begin
                    $display("unexpected result transfer at %0t", $realtime);
                    errors++;
                end else begin
                    t_out_item want;
                    want = expected_results.pop_front();
                    if (o_result.result_y !== want.result_y)
                        report_mismatch("result_y", o_result.result_y, want.result_y);
                    if (o_result.status !== want.status)
                        report_mismatch("status", o_result.status, want.status);
                    if (o_result.entries_held !== want.entries_held)
                        report_mismatch("entries_held", o_result.entries_held,
                                        want.entries_held);
                end
            end
            pop <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic add_item(input logic [1:0] m, input int x, input int y);
        t_in_item it;
        it.mode = m;
        it.key_x = x;
        it.value_y = y;
        pending_items.push_back(it);
    endtask

    function automatic int random_coord();
        case ($urandom_range(9))
            0:       return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
            1, 2, 3: return int'($urandom);
            default: return int'($urandom_range(32'h00200000)) - 32'h00100000;
        endcase
    endfunction

    task automatic wait_drained();
        while (pending_items.size() != 0 || push || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_extrap(input bit v);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= v;
        extrap_on = v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // clear, build a table (mostly rising in x) and query it
    task automatic random_table_run();
        int xs[$];
        int ext[$];
        int n, j, x, lo, hi;
        n = ($urandom_range(19) == 0) ? $urandom_range(66, 60) : $urandom_range(6, 1);
        add_item(MODE_CLEAR, int'($urandom), int'($urandom));
        for (j = 0; j < n; j++) xs.push_back(random_coord());
        if ($urandom_range(7) != 0) xs.sort();
        if (n > 2 && $urandom_range(5) == 0) xs[1] = xs[0];
        foreach (xs[j]) add_item(MODE_APPEND, xs[j], random_coord());
        ext = xs.min();
        lo = ext[0];
        ext = xs.max();
        hi = ext[0];
        for (j = $urandom_range(6, 1); j > 0; j--) begin
            case ($urandom_range(9))
                0:       x = random_coord();
                1, 2:    x = xs[$urandom_range(n - 1)];
                3:       x = xs[$urandom_range(n - 1)] + int'($urandom_range(4)) - 2;
                4:       add_item(MODE_UNUSED, int'($urandom), int'($urandom));
                default: x = lo + int'($urandom_range(hi - lo));
            endcase
            add_item(MODE_QUERY, x, int'($urandom));
        end
    endtask

    initial begin
        int ph, j;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_data = 1'b0;
        push = 1'b0;
        pop = 1'b0;
        i_item = '0;
        num_points = 0;
        extrap_on = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        errors = 0;
        cycles = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: too few points, extremes, exact last hit, full table
        add_item(MODE_QUERY, 0, 0);
        add_item(MODE_APPEND, 32'h80000000, 32'h7fffffff);
        add_item(MODE_QUERY, 0, 0);
        add_item(MODE_APPEND, 32'h7fffffff, 32'h80000000);
        add_item(MODE_QUERY, 0, 32'hffffffff);
        add_item(MODE_QUERY, 32'h80000000, 0);
        add_item(MODE_QUERY, 32'h7fffffff, 0);
        add_item(MODE_QUERY, 32'h80000001, 0);
        add_item(MODE_UNUSED, 32'hffffffff, 32'hffffffff);
        add_item(MODE_APPEND, 32'h7fffffff, 0);
        add_item(MODE_QUERY, 5, 0);
        add_item(MODE_CLEAR, 0, 0);
        add_item(MODE_APPEND, 32'h00010000, 32'h00020000);
        add_item(MODE_APPEND, 32'h00030000, 32'hfffe0000);
        add_item(MODE_QUERY, 0, 0);
        add_item(MODE_QUERY, 32'h00050000, 0);
        add_item(MODE_QUERY, 32'h00020000, 0);
        wait_drained();
        write_extrap(1'b1);
        add_item(MODE_QUERY, 0, 0);
        add_item(MODE_QUERY, 32'h00050000, 0);
        add_item(MODE_QUERY, 32'h80000000, 0);
        add_item(MODE_CLEAR, 0, 0);
        for (j = 0; j < MAX_POINTS; j++) add_item(MODE_APPEND, j << 20, int'($urandom));
        add_item(MODE_APPEND, 32'h7fffffff, 0);
        add_item(MODE_QUERY, 32'h03f00001, 0);
        add_item(MODE_QUERY, 32'h00080000, 0);
        wait_drained();

        for (ph = 0; ph < 4; ph++) begin
            write_extrap(ph[0]);
            send_idle_pct = (ph == 1 || ph == 3) ? 49 : 0;
            recv_idle_pct = (ph >= 2) ? 49 : 0;
            if (ph == 3) begin
                send_idle_pct = 16;
                recv_idle_pct = 16;
            end
            while (pending_items.size() < 360) random_table_run();
            wait_drained();
        end

        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
